FILE: rtl/shk_pkg.sv
// Shared types and constants for the shock tap/slide classifier.
// No dependencies; the top level imports this package.
`timescale 1ns / 1ps

package shk_pkg;

    // Width of the window length register and of the fill counter.
    localparam int LEN_BITS = 7;
    localparam int LEN_MAX = (1 << LEN_BITS) - 1;
    // Window length after reset.
    localparam int LEN_RESET = 16;

    // Configuration port address width: five registers at byte addresses 4*i.
    localparam int ADDR_BITS = 5;
    localparam int REG_IDX_BITS = 3;

    // Register indexes.
    localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_BASELINE = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_NOISE_FLOOR = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_TAP_THRESHOLD = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SLIDE_THRESHOLD = 3'd4;

    // Register reset values.
    localparam int BASELINE_RESET = 512;
    localparam int NOISE_FLOOR_RESET = 0;
    localparam int TAP_THRESHOLD_RESET = 100;
    localparam int SLIDE_THRESHOLD_RESET = 30;

    // Gesture codes.
    localparam int GESTURE_BITS = 2;
    localparam logic [GESTURE_BITS-1:0] GESTURE_NONE = 2'd0;
    localparam logic [GESTURE_BITS-1:0] GESTURE_SLIDE = 2'd1;
    localparam logic [GESTURE_BITS-1:0] GESTURE_TAP = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_SETUP,
        ST_DIVIDE,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/shk_interfaces.sv
// Valid/ready stream interfaces for the sample input and the result output.
// No dependencies; the sample and mean widths follow the SAMPLE_BITS parameter of each instance.
`timescale 1ns / 1ps

// Raw sample channel.
interface shk_sample_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// Classification result channel.
interface shk_result_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             gesture;
    logic [SAMPLE_BITS-1:0] mean_level;

    modport source (output valid, output gesture, output mean_level, input ready);
    modport sink (input valid, input gesture, input mean_level, output ready);
endinterface

FILE: rtl/shock_tap_slide_classifier_unit.sv
// Top level of the shock tap/slide classifier: configuration registers,
// window store, running total, serial divider and result register.
// Depends on shk_pkg and the stream interfaces in shk_interfaces.sv.
`timescale 1ns / 1ps

// How the block is used
// ---------------------
// Raw sensor readings enter on sample_in, one item per handshake; each gives
// exactly one item on result_out with the gesture code (none, slide, tap)
// and the moving average of the gated deviations.
// The configuration registers sit on a small APB-style port (pready always
// high) at byte addresses 0, 4, 8, 12 and 16. Writing the window length
// restarts the fill phase of the average; write registers only while no item
// is in flight.
// An item is processed by a sequencer around one subtract-and-compare
// divider that yields one quotient bit per cycle. The sequencer steps
// through fetch, update, setup, the divider iterations and done; the result
// is registered as it leaves the done state, and sample_in.ready rises at
// that same edge, so a new item is accepted only once the last one's
// result has been registered.
// A result waits in the output register while result_out.ready is low;
// the next sample can be accepted meanwhile, and the sequencer holds its
// finished mean until the output register is free.
// Reset clears the control state and restores the register reset values.
// The window store has no reset and needs no clearing pass: the fill phase
// writes every slot before it is read.
module shock_tap_slide_classifier_unit #(
    parameter int MAX_WINDOW = 64,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    shk_sample_if.sink                   sample_in,
    shk_result_if.source                 result_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [shk_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import shk_pkg::*;

    localparam int PTR_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_CAP = (MAX_WINDOW > LEN_MAX) ? LEN_MAX : MAX_WINDOW;
    localparam int LEN_INIT = (LEN_RESET > LEN_CAP) ? LEN_CAP : LEN_RESET;
    localparam int TOT_BITS = SAMPLE_BITS + LEN_BITS;
    localparam int CMP_BITS = (PTR_BITS + 1 > LEN_BITS) ? PTR_BITS + 1 : LEN_BITS;
    localparam int CNT_BITS = $clog2(SAMPLE_BITS);

    // Configuration registers.
    logic [LEN_BITS-1:0]    window_length_reg;
    logic [SAMPLE_BITS-1:0] baseline_reg;
    logic [SAMPLE_BITS-1:0] noise_floor_reg;
    logic [SAMPLE_BITS-1:0] tap_threshold_reg;
    logic [SAMPLE_BITS-1:0] slide_threshold_reg;

    // Window state.
    logic [PTR_BITS-1:0]    pos_reg;
    logic [LEN_BITS-1:0]    fill_count_reg;
    logic                   window_full_reg;
    logic [TOT_BITS-1:0]    total_reg;

    // Per-item working registers.
    state_t                 state_reg;
    state_t                 state_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] dev_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [LEN_BITS-1:0]    divisor_reg;
    logic [LEN_BITS-1:0]    rem_reg;
    logic [SAMPLE_BITS-1:0] quo_reg;
    logic [CNT_BITS-1:0]    cnt_reg;

    // Result register.
    logic                   out_valid_reg;
    logic [1:0]             gesture_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;

    // Window store.
    logic [SAMPLE_BITS-1:0] window_mem [MAX_WINDOW];

    // Control outputs of the sequencer.
    logic in_ready;
    logic mem_rd_en;
    logic mem_wr_en;
    logic out_free;
    logic out_load;

    // Configuration write decode.
    logic                    cfg_write;
    logic [REG_IDX_BITS-1:0] cfg_index;
    logic [LEN_BITS-1:0]     len_raw;
    logic [LEN_BITS-1:0]     len_next;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[ADDR_BITS-1:2];
    assign len_raw = pwdata[LEN_BITS-1:0];

    // A zero window length counts as one; lengths beyond the store saturate.
    always_comb
    begin
        if (len_raw == '0)
            len_next = LEN_BITS'(1);
        else if (32'(len_raw) > LEN_CAP)
            len_next = LEN_BITS'(LEN_CAP);
        else
            len_next = len_raw;
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_index)
            REG_WINDOW_LENGTH:   prdata = 32'(window_length_reg);
            REG_BASELINE:        prdata = 32'(baseline_reg);
            REG_NOISE_FLOOR:     prdata = 32'(noise_floor_reg);
            REG_TAP_THRESHOLD:   prdata = 32'(tap_threshold_reg);
            REG_SLIDE_THRESHOLD: prdata = 32'(slide_threshold_reg);
            default:             prdata = '0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg   <= LEN_BITS'(LEN_INIT);
            baseline_reg        <= SAMPLE_BITS'(BASELINE_RESET);
            noise_floor_reg     <= SAMPLE_BITS'(NOISE_FLOOR_RESET);
            tap_threshold_reg   <= SAMPLE_BITS'(TAP_THRESHOLD_RESET);
            slide_threshold_reg <= SAMPLE_BITS'(SLIDE_THRESHOLD_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH:   window_length_reg <= len_next;
                REG_BASELINE:        baseline_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_NOISE_FLOOR:     noise_floor_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_TAP_THRESHOLD:   tap_threshold_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_SLIDE_THRESHOLD: slide_threshold_reg <= pwdata[SAMPLE_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_in.valid)
                    state_next = ST_FETCH;
            end
            ST_FETCH:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        out_free = !out_valid_reg || result_out.ready;
        in_ready = 1'b0;
        mem_rd_en = 1'b0;
        mem_wr_en = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_FETCH:  mem_rd_en = 1'b1;
            ST_UPDATE: mem_wr_en = 1'b1;
            ST_DONE:   out_load = out_free;
            default:   ;
        endcase
    end

    assign sample_in.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Gated absolute deviation and the next ring position.
    logic [SAMPLE_BITS-1:0] dev_abs;
    logic [SAMPLE_BITS-1:0] dev_next;
    logic [CMP_BITS-1:0]    pos_inc;
    logic [PTR_BITS-1:0]    pos_next;

    always_comb
    begin
        if (sample_reg >= baseline_reg)
            dev_abs = sample_reg - baseline_reg;
        else
            dev_abs = baseline_reg - sample_reg;
        dev_next = (dev_abs < noise_floor_reg) ? '0 : dev_abs;

        pos_inc = CMP_BITS'(pos_reg) + CMP_BITS'(1);
        if (pos_inc >= CMP_BITS'(window_length_reg))
            pos_next = '0;
        else
            pos_next = pos_inc[PTR_BITS-1:0];
    end

    // Running total, fill count and divisor for this item.
    logic [LEN_BITS-1:0] fill_next;
    logic [TOT_BITS-1:0] total_next;

    always_comb
    begin
        fill_next = fill_count_reg + LEN_BITS'(1);
        if (window_full_reg)
            total_next = total_reg - TOT_BITS'(rd_data_reg) + TOT_BITS'(dev_reg);
        else
            total_next = total_reg + TOT_BITS'(dev_reg);
    end

    // One restoring division step: shift in the next dividend bit.
    logic [LEN_BITS:0] trial;
    logic              trial_ok;

    assign trial = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign trial_ok = trial >= {1'b0, divisor_reg};

    // Window state: restarted by a window length write, advanced per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= PTR_BITS'(LEN_INIT - 1);
            fill_count_reg  <= '0;
            window_full_reg <= 1'b0;
            total_reg       <= '0;
        end
        else if (cfg_write && cfg_index == REG_WINDOW_LENGTH)
        begin
            pos_reg         <= PTR_BITS'(len_next - LEN_BITS'(1));
            fill_count_reg  <= '0;
            window_full_reg <= 1'b0;
            total_reg       <= '0;
        end
        else if (state_reg == ST_FETCH)
        begin
            pos_reg <= pos_next;
        end
        else if (state_reg == ST_UPDATE)
        begin
            total_reg <= total_next;
            if (!window_full_reg)
            begin
                fill_count_reg <= fill_next;
                if (fill_next >= window_length_reg)
                    window_full_reg <= 1'b1;
            end
        end
    end

    // Working registers of one item and the serial divider.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_in.valid)
                    sample_reg <= sample_in.sample;
            end
            ST_FETCH:
            begin
                dev_reg <= dev_next;
            end
            ST_UPDATE:
            begin
                divisor_reg <= window_full_reg ? window_length_reg : fill_next;
            end
            ST_SETUP:
            begin
                // The quotient fits SAMPLE_BITS, so the upper dividend bits
                // are already below the divisor.
                rem_reg <= total_reg[TOT_BITS-1:SAMPLE_BITS];
                quo_reg <= total_reg[SAMPLE_BITS-1:0];
                cnt_reg <= CNT_BITS'(SAMPLE_BITS - 1);
            end
            ST_DIVIDE:
            begin
                rem_reg <= trial_ok ? LEN_BITS'(trial - {1'b0, divisor_reg})
                                    : trial[LEN_BITS-1:0];
                quo_reg <= {quo_reg[SAMPLE_BITS-2:0], trial_ok};
                cnt_reg <= cnt_reg - CNT_BITS'(1);
            end
            default: ;
        endcase
    end

    // Window store: the oldest entry is read in the fetch step and the new
    // deviation written in the update step.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            window_mem[pos_reg] <= dev_reg;
        if (mem_rd_en)
            rd_data_reg <= window_mem[pos_next];
    end

    // Classification of the mean.
    logic [1:0] gesture_next;

    always_comb
    begin
        if (quo_reg > tap_threshold_reg)
            gesture_next = GESTURE_TAP;
        else if (quo_reg > slide_threshold_reg)
            gesture_next = GESTURE_SLIDE;
        else
            gesture_next = GESTURE_NONE;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            gesture_reg <= gesture_next;
            mean_reg    <= quo_reg;
        end
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.gesture = gesture_reg;
    assign result_out.mean_level = mean_reg;

    // Checks on the window bookkeeping and the divider.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= window_length_reg)
        else $error("fill count beyond window length");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        window_full_reg |-> fill_count_reg == window_length_reg)
        else $error("full window without a complete fill count");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_BITS'(pos_reg) < CMP_BITS'(window_length_reg))
        else $error("write position outside the window");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> divisor_reg != '0 && rem_reg < divisor_reg)
        else $error("divider remainder not below a nonzero divisor");

    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_valid_reg && !result_out.ready
        |=> state_reg == ST_DONE && out_valid_reg)
        else $error("finished mean dropped while the result register was full");

endmodule
